// ===== src/pcsf_pkg.sv =====
package pcsf_pkg;

   // default geometry of the block
   localparam int MAX_VERTICES = 16;
   localparam int COORD_WIDTH  = 10;
   localparam int MIN_COUNT    = 3;

   // fixed field widths of the channels
   localparam int INDEX_W = 4;
   localparam int FIELD_W = 10;
   localparam int SPAN_W  = 12;
   localparam int COUNT_W = 5;

   // operation codes
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_ROW   = 1'b1;

   // side-band flags that travel with one edge through the divider
   typedef struct packed {
      logic live;        // slot carries an edge
      logic keep;        // edge counts (row item, not horizontal)
      logic last;        // final edge of the walk
      logic raise_left;  // edge raises the left bound
      logic neg;         // quotient is negative
   } tag_type;

endpackage

// ===== src/pcsf_req_if.sv =====
interface pcsf_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic [pcsf_pkg::INDEX_W-1:0]        vertex_index;
   logic [pcsf_pkg::FIELD_W-1:0]        vertex_x;
   logic [pcsf_pkg::FIELD_W-1:0]        vertex_y;
   logic [pcsf_pkg::FIELD_W-1:0]        row_y;

   modport source (output valid, operation, vertex_index, vertex_x, vertex_y, row_y,
                   input ready);
   modport sink   (input valid, operation, vertex_index, vertex_x, vertex_y, row_y,
                   output ready);
endinterface

// ===== src/pcsf_rsp_if.sv =====
interface pcsf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                span_valid;
   logic signed [pcsf_pkg::SPAN_W-1:0]  span_left;
   logic signed [pcsf_pkg::SPAN_W-1:0]  span_right;
   logic [pcsf_pkg::FIELD_W-1:0]        row_min;
   logic [pcsf_pkg::FIELD_W-1:0]        row_max;

   modport source (output valid, span_valid, span_left, span_right, row_min, row_max,
                   input ready);
   modport sink   (input valid, span_valid, span_left, span_right, row_min, row_max,
                   output ready);
endinterface

// ===== src/pcsf_div_cell.sv =====
module pcsf_div_cell #(
   parameter int COORD_WIDTH = pcsf_pkg::COORD_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pcsf_pkg::tag_type           tag_in,
   input  logic [COORD_WIDTH-1:0]      rem_in,
   input  logic [2*COORD_WIDTH:0]      work_in,
   input  logic [COORD_WIDTH-1:0]      div_in,
   output pcsf_pkg::tag_type           tag_out,
   output logic [COORD_WIDTH-1:0]      rem_out,
   output logic [2*COORD_WIDTH:0]      work_out,
   output logic [COORD_WIDTH-1:0]      div_out
);

   localparam int QW = 2 * COORD_WIDTH + 1;

   pcsf_pkg::tag_type          tag_ff;
   logic [COORD_WIDTH-1:0]     rem_ff;
   logic [QW-1:0]              work_ff;
   logic [COORD_WIDTH-1:0]     div_ff;
   logic [COORD_WIDTH:0]       acc;
   logic [COORD_WIDTH:0]       diff;
   logic                       take;

   // one restoring step: bring down the next dividend bit, trial subtract
   assign acc  = {rem_in, work_in[QW-1]};
   assign diff = acc - {1'b0, div_in};
   assign take = (acc >= {1'b0, div_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   // advance remainder, quotient and divisor to the next cell
   always_ff @(posedge clock) begin
      rem_ff  <= take ? diff[COORD_WIDTH-1:0] : acc[COORD_WIDTH-1:0];
      work_ff <= {work_in[QW-2:0], take};
      div_ff  <= div_in;
   end

   assign tag_out  = tag_ff;
   assign rem_out  = rem_ff;
   assign work_out = work_ff;
   assign div_out  = div_ff;

endmodule

// ===== src/convex_polygon_span_fill_unit.sv =====
// Convex polygon span fill.
// req_channel takes items: a store item writes one vertex slot, a row item asks
// for the span that the stored convex polygon covers on scanline row_y.
// rsp_channel returns exactly one result per item, in order; row_min and
// row_max give the y extent of the vertices in use.
// csr_write_enable / csr_write_data set the vertex count; write it only while
// no item is in flight.
// Each item reads the vertices one a cycle (count + 1 reads), then each edge
// passes the multiply stage, the sum stage and a chain of 2*COORD_WIDTH+1
// divider cells, one quotient bit per cell; the next item is taken once the
// result is in the output register.
// Reset clears the control state and sets the count to three; vertex slots
// hold nothing defined until written.
// A stalled receiver holds the result in the output register; the next item
// may be accepted meanwhile but its result waits until that one is taken.
module convex_polygon_span_fill_unit #(
   parameter int MAX_VERTICES = pcsf_pkg::MAX_VERTICES,
   parameter int COORD_WIDTH  = pcsf_pkg::COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   pcsf_req_if.sink                      req_channel,
   pcsf_rsp_if.source                    rsp_channel,
   input  logic                          csr_write_enable,
   input  logic [pcsf_pkg::COUNT_W-1:0]  csr_write_data
);

   localparam int C  = COORD_WIDTH;
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int QW = 2 * C + 1;
   localparam int PW = 2 * C + 2;
   localparam int SW = C + 2;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_SEND  = 2'd3;

   localparam logic signed [SW-1:0] SPAN_LOW  = -SW'(1);
   localparam logic signed [SW-1:0] SPAN_HIGH = SW'(1) << C;

   // vertex memory
   logic [C-1:0]  mem_x [MAX_VERTICES];
   logic [C-1:0]  mem_y [MAX_VERTICES];

   logic [pcsf_pkg::COUNT_W-1:0] count_ff;
   logic [1:0]                   state_ff;
   logic                         op_ff;
   logic [C-1:0]                 row_ff;
   logic [CW-1:0]                n_ff;
   logic [CW-1:0]                k_ff;
   logic [CW-1:0]                n_in;
   logic                         req_fire;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;

   // read stage
   logic                         rv_ff;
   logic                         rfirst_ff;
   logic                         rwrap_ff;
   logic [C-1:0]                 rx_ff;
   logic [C-1:0]                 ry_ff;
   logic [C-1:0]                 px_ff;
   logic [C-1:0]                 py_ff;
   logic [C-1:0]                 ymin_ff;
   logic [C-1:0]                 ymax_ff;

   // multiply stage
   logic signed [C:0]            den;
   logic signed [C:0]            dy;
   logic signed [C:0]            dx;
   pcsf_pkg::tag_type            m_tag_ff;
   logic                         m_dneg_ff;
   logic [C-1:0]                 m_div_ff;
   logic signed [PW-1:0]         m_p1_ff;
   logic signed [PW-1:0]         m_p2_ff;

   // sum stage
   logic signed [PW-1:0]         num;
   logic [PW-1:0]                num_mag;
   pcsf_pkg::tag_type            s_tag_ff;
   logic [QW-1:0]                s_work_ff;
   logic [C-1:0]                 s_div_ff;
   pcsf_pkg::tag_type            s_tag_in;

   // divider chain
   pcsf_pkg::tag_type            tag_c  [QW+1];
   logic [C-1:0]                 rem_c  [QW+1];
   logic [QW-1:0]                work_c [QW+1];
   logic [C-1:0]                 div_c  [QW+1];

   // bounds and output
   logic signed [SW-1:0]         left_ff;
   logic signed [SW-1:0]         right_ff;
   logic signed [SW-1:0]         t_sat;
   pcsf_pkg::tag_type            end_tag;
   logic [QW-1:0]                q;
   logic                         send;
   logic                         rsp_valid_ff;
   logic                         sv_ff;
   logic signed [pcsf_pkg::SPAN_W-1:0] sl_ff;
   logic signed [pcsf_pkg::SPAN_W-1:0] sr_ff;
   logic [pcsf_pkg::FIELD_W-1:0] rmin_ff;
   logic [pcsf_pkg::FIELD_W-1:0] rmax_ff;

   assign req_channel.ready = (state_ff == ST_IDLE);
   assign req_fire = req_channel.valid && req_channel.ready;

   // clamp the configured count to the supported range
   always_comb begin
      int c;
      c = int'(count_ff);
      if (c < pcsf_pkg::MIN_COUNT) c = pcsf_pkg::MIN_COUNT;
      if (c > MAX_VERTICES) c = MAX_VERTICES;
      n_in = CW'(c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= pcsf_pkg::COUNT_W'(pcsf_pkg::MIN_COUNT);
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   // vertex write on a store transfer, slots beyond the memory dropped
   assign wr_en   = req_fire && (req_channel.operation == pcsf_pkg::OP_STORE)
                    && (int'(req_channel.vertex_index) < MAX_VERTICES);
   assign wr_addr = AW'(req_channel.vertex_index);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= C'(req_channel.vertex_x);
         mem_y[wr_addr] <= C'(req_channel.vertex_y);
      end
   end

   // walk the vertices in order and wrap back to the first one
   assign rd_en   = (state_ff == ST_WALK);
   assign rd_addr = (k_ff == n_ff) ? '0 : k_ff[AW-1:0];

   always_ff @(posedge clock) begin
      rx_ff <= mem_x[rd_addr];
      ry_ff <= mem_y[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rfirst_ff <= (k_ff == '0);
      rwrap_ff  <= (k_ff == n_ff);
      if (rv_ff) begin
         px_ff <= rx_ff;
         py_ff <= ry_ff;
      end
      // track the y extent over the vertices in use
      if (rv_ff && !rwrap_ff) begin
         if (rfirst_ff) begin
            ymin_ff <= ry_ff;
            ymax_ff <= ry_ff;
         end else begin
            if (ry_ff < ymin_ff) ymin_ff <= ry_ff;
            if (ry_ff > ymax_ff) ymax_ff <= ry_ff;
         end
      end
   end

   // edge from the previous vertex to the one just read
   assign den = signed'({1'b0, ry_ff}) - signed'({1'b0, py_ff});
   assign dy  = signed'({1'b0, row_ff}) - signed'({1'b0, py_ff});
   assign dx  = signed'({1'b0, rx_ff}) - signed'({1'b0, px_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         m_tag_ff <= '0;
      end else begin
         m_tag_ff.live       <= rv_ff && !rfirst_ff;
         m_tag_ff.keep       <= (den != '0) && (op_ff == pcsf_pkg::OP_ROW);
         m_tag_ff.last       <= rwrap_ff;
         m_tag_ff.raise_left <= (py_ff >= ry_ff);
         m_tag_ff.neg        <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      m_dneg_ff <= den[C];
      m_div_ff  <= den[C] ? C'(-den) : C'(den);
      m_p1_ff   <= PW'(signed'({1'b0, px_ff}) * den);
      m_p2_ff   <= PW'(dy * dx);
   end

   // form the numerator and split it into sign and magnitude
   assign num     = m_p1_ff + m_p2_ff;
   assign num_mag = num[PW-1] ? PW'(-num) : PW'(num);

   always_comb begin
      s_tag_in     = m_tag_ff;
      s_tag_in.neg = num[PW-1] ^ m_dneg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_tag_ff <= '0;
      end else begin
         s_tag_ff <= s_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      s_work_ff <= num_mag[QW-1:0];
      s_div_ff  <= m_div_ff;
   end

   assign tag_c[0]  = s_tag_ff;
   assign rem_c[0]  = '0;
   assign work_c[0] = s_work_ff;
   assign div_c[0]  = s_div_ff;

   // one cell per quotient bit
   for (genvar g = 0; g < QW; g++) begin : g_cell
      pcsf_div_cell #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tag_in   (tag_c[g]),
         .rem_in   (rem_c[g]),
         .work_in  (work_c[g]),
         .div_in   (div_c[g]),
         .tag_out  (tag_c[g+1]),
         .rem_out  (rem_c[g+1]),
         .work_out (work_c[g+1]),
         .div_out  (div_c[g+1])
      );
   end

   assign end_tag = tag_c[QW];
   assign q       = work_c[QW];

   // saturate the truncated quotient; any negative value lands on the low bound
   always_comb begin
      if (end_tag.neg && (q != '0)) begin
         t_sat = SPAN_LOW;
      end else if (q > (QW'(1) << C)) begin
         t_sat = SPAN_HIGH;
      end else begin
         t_sat = signed'({1'b0, q[C:0]});
      end
   end

   assign send = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_channel.ready);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) state_ff <= ST_WALK;
            end
            ST_WALK: begin
               if (k_ff == n_ff) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (end_tag.live && end_tag.last) state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (send) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // item context, walk counter and bounds
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_channel.operation;
         row_ff   <= C'(req_channel.row_y);
         n_ff     <= n_in;
         k_ff     <= '0;
         left_ff  <= SPAN_LOW;
         right_ff <= SPAN_HIGH;
      end else begin
         if (rd_en) k_ff <= k_ff + CW'(1);
         if (end_tag.live && end_tag.keep) begin
            if (end_tag.raise_left) begin
               if (t_sat > left_ff) left_ff <= t_sat;
            end else begin
               if (t_sat < right_ff) right_ff <= t_sat;
            end
         end
      end
   end

   // output register, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (send) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         rmin_ff <= pcsf_pkg::FIELD_W'(ymin_ff);
         rmax_ff <= pcsf_pkg::FIELD_W'(ymax_ff);
         if (op_ff == pcsf_pkg::OP_ROW) begin
            sv_ff <= (row_ff >= ymin_ff) && (row_ff <= ymax_ff) && (left_ff < right_ff);
            sl_ff <= pcsf_pkg::SPAN_W'(left_ff);
            sr_ff <= pcsf_pkg::SPAN_W'(right_ff);
         end else begin
            sv_ff <= 1'b0;
            sl_ff <= '0;
            sr_ff <= '0;
         end
      end
   end

   assign rsp_channel.valid      = rsp_valid_ff;
   assign rsp_channel.span_valid = sv_ff;
   assign rsp_channel.span_left  = sl_ff;
   assign rsp_channel.span_right = sr_ff;
   assign rsp_channel.row_min    = rmin_ff;
   assign rsp_channel.row_max    = rmax_ff;

endmodule
